### rtl/core/pdfe_pkg.sv
`timescale 1ns / 1ps
// pdfe_pkg: shared types and constants for the pulse distance frame encoder
// no dependencies

package pdfe_pkg;

    localparam int DURATION_BITS = 16;
    localparam int NUM_SLOTS     = 20;
    localparam int SLOT_BITS     = $clog2(NUM_SLOTS);
    localparam int MAX_BITS      = 8;
    localparam int PADDR_BITS    = 5;

    typedef logic [DURATION_BITS-1:0] dur_t;
    typedef logic [NUM_SLOTS-1:0]     slot_mask_t;
    typedef logic [SLOT_BITS-1:0]     slot_idx_t;

    // slot layout of one byte
    localparam slot_idx_t SLOT_HDR_MARK = SLOT_BITS'(0);
    localparam slot_idx_t SLOT_HDR_SPACE = SLOT_BITS'(1);
    localparam slot_idx_t SLOT_BIT_BASE = SLOT_BITS'(2);
    localparam slot_idx_t SLOT_FTR_MARK = SLOT_BITS'(18);
    localparam slot_idx_t SLOT_FTR_SPACE = SLOT_BITS'(19);

    typedef enum logic [2:0] {
        REG_HEADER_TIMES = 3'd0,
        REG_ONE_MARK     = 3'd1,
        REG_ONE_SPACE    = 3'd2,
        REG_ZERO_MARK    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_FOOTER_TIMES = 3'd5,
        REG_LAST_SPACE   = 3'd6,
        REG_MODE         = 3'd7
    } reg_idx_t;

    localparam logic [1:0] MODE_RESET = 2'b01;

endpackage

### rtl/core/pulse_distance_frame_encoder.sv
`timescale 1ns / 1ps
// pulse_distance_frame_encoder: turns frame bytes into mark/space durations
// depends on pdfe_pkg
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+---------------------------------
//  s_      | s_valid s_ready s_data_byte s_bit_count | one frame byte word
//          | s_frame_end                             |
//  m_      | m_valid m_ready m_duration m_is_mark    | one duration word
//          | m_run_last                              |
//  apb     | psel penable pwrite paddr pwdata prdata | register access, byte addr 4*i
//
// one duration word leaves per cycle unless m_ready holds it; a byte makes
// zero to 20 durations, all through the single output register
// the next byte is taken in the cycle its predecessor's final word loads
// a byte that makes no durations is taken and retired with no output word
// aresetn is synchronous, active low; it resets control state and registers
// m_ready low holds the output word and stalls the slot walk

module pulse_distance_frame_encoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // byte input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic [3:0]                     s_bit_count,
    input  logic                           s_frame_end,
    // duration output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pdfe_pkg::DURATION_BITS-1:0] m_duration,
    output logic                           m_is_mark,
    output logic                           m_run_last,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdfe_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import pdfe_pkg::*;

    // configuration registers
    logic [31:0] header_times_reg;
    dur_t        one_mark_reg;
    dur_t        one_space_reg;
    dur_t        zero_mark_reg;
    dur_t        zero_space_reg;
    logic [31:0] footer_times_reg;
    dur_t        last_space_reg;
    logic [1:0]  mode_reg;

    // item state: remaining slots, reordered bits, frame end flag
    slot_mask_t           rem_reg;
    slot_mask_t           rem_next;
    logic [MAX_BITS-1:0]  bits_reg;
    logic                 last_reg;
    logic                 header_pending_reg;

    // output register
    logic m_valid_reg;
    dur_t m_duration_reg;
    logic m_is_mark_reg;
    logic m_run_last_reg;

    logic       cfg_wr;
    reg_idx_t   cfg_idx;
    logic       s_accept;
    logic       out_load;
    logic       final_slot;
    slot_mask_t rem_after;
    slot_idx_t  sel;
    slot_mask_t mask_in;
    logic [MAX_BITS-1:0] bits_in;
    logic [3:0] cnt_sat;
    logic [3:0] pos;
    logic [3:0] bit_k;
    logic [2:0] bit_i;
    logic       bit_h;
    logic       bit_v;
    dur_t       bit_mk;
    dur_t       bit_sp;
    dur_t       dur_sel;
    logic       mark_sel;
    logic       footer_zero;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_times_reg <= '0;
            one_mark_reg     <= '0;
            one_space_reg    <= '0;
            zero_mark_reg    <= '0;
            zero_space_reg   <= '0;
            footer_times_reg <= '0;
            last_space_reg   <= '0;
            mode_reg         <= MODE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HEADER_TIMES: header_times_reg <= pwdata;
                REG_ONE_MARK:     one_mark_reg     <= pwdata[DURATION_BITS-1:0];
                REG_ONE_SPACE:    one_space_reg    <= pwdata[DURATION_BITS-1:0];
                REG_ZERO_MARK:    zero_mark_reg    <= pwdata[DURATION_BITS-1:0];
                REG_ZERO_SPACE:   zero_space_reg   <= pwdata[DURATION_BITS-1:0];
                REG_FOOTER_TIMES: footer_times_reg <= pwdata;
                REG_LAST_SPACE:   last_space_reg   <= pwdata[DURATION_BITS-1:0];
                REG_MODE:         mode_reg         <= pwdata[1:0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    // read mux, unaligned reads return zero
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_HEADER_TIMES: prdata = header_times_reg;
            REG_ONE_MARK:     prdata = {16'd0, one_mark_reg};
            REG_ONE_SPACE:    prdata = {16'd0, one_space_reg};
            REG_ZERO_MARK:    prdata = {16'd0, zero_mark_reg};
            REG_ZERO_SPACE:   prdata = {16'd0, zero_space_reg};
            REG_FOOTER_TIMES: prdata = footer_times_reg;
            REG_LAST_SPACE:   prdata = {16'd0, last_space_reg};
            REG_MODE:         prdata = {30'd0, mode_reg};
            default:          prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00) begin
            prdata = '0;
        end
    end

    // ---------------- input side: build slot mask ----------------
    // counts above eight send eight bits
    assign cnt_sat = (s_bit_count > 4'd8) ? 4'd8 : s_bit_count;

    always_comb begin
        mask_in = '0;
        bits_in = '0;
        pos     = '0;
        // header halves, only on the first byte of a frame
        mask_in[SLOT_HDR_MARK]  = header_pending_reg && (header_times_reg[31:16] != '0);
        mask_in[SLOT_HDR_SPACE] = header_pending_reg && (header_times_reg[15:0] != '0);
        for (int i = 0; i < MAX_BITS; i++) begin
            // bit i in send order; msb first counts down from the top used bit
            pos = mode_reg[0] ? (cnt_sat - 4'd1 - 4'(i)) : 4'(i);
            if (4'(i) < cnt_sat) begin
                bits_in[i]              = s_data_byte[pos[2:0]];
                mask_in[2 + 2 * i]      = 1'b1;
                mask_in[3 + 2 * i]      = !mode_reg[1];
            end
        end
        // footer halves on the frame's last byte
        mask_in[SLOT_FTR_MARK]  = s_frame_end && (footer_times_reg[31:16] != '0);
        mask_in[SLOT_FTR_SPACE] = s_frame_end && (footer_times_reg[15:0] != '0);
    end

    // ---------------- slot walk ----------------
    // lowest pending slot goes out next
    always_comb begin
        sel = '0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
            if (rem_reg[j]) begin
                sel = SLOT_BITS'(j);
            end
        end
    end

    assign rem_after  = rem_reg & (rem_reg - slot_mask_t'(1));
    assign final_slot = (rem_after == '0);
    assign out_load   = (rem_reg != '0) && (!m_valid_reg || m_ready);
    // take a new byte when nothing is pending or the last slot is leaving now
    assign s_ready    = (rem_reg == '0) || (out_load && final_slot);
    assign s_accept   = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            rem_next = mask_in;
        end else if (out_load) begin
            rem_next = rem_after;
        end else begin
            rem_next = rem_reg;
        end
    end

    // bit slot decode: pair index and half
    assign bit_k  = 4'(sel - SLOT_BIT_BASE);
    assign bit_i  = bit_k[3:1];
    assign bit_h  = bit_k[0];
    assign bit_v  = bits_reg[bit_i];
    assign bit_mk = bit_v ? one_mark_reg : zero_mark_reg;
    assign bit_sp = bit_v ? one_space_reg : zero_space_reg;
    assign footer_zero = (footer_times_reg == '0);

    always_comb begin
        priority if (sel == SLOT_HDR_MARK) begin
            dur_sel  = header_times_reg[31:16];
            mark_sel = 1'b1;
        end else if (sel == SLOT_HDR_SPACE) begin
            dur_sel  = header_times_reg[15:0];
            mark_sel = 1'b0;
        end else if (sel == SLOT_FTR_MARK) begin
            dur_sel  = footer_times_reg[31:16];
            mark_sel = 1'b1;
        end else if (sel == SLOT_FTR_SPACE) begin
            dur_sel  = footer_times_reg[15:0];
            mark_sel = 1'b0;
        end else if (mode_reg[1]) begin
            // single duration per bit: even bits mark, odd bits space
            dur_sel  = bit_i[0] ? bit_sp : bit_mk;
            mark_sel = !bit_i[0];
        end else begin
            dur_sel  = bit_h ? bit_sp : bit_mk;
            mark_sel = !bit_h;
        end
        // final word of a frame with no footer takes last_space
        if (final_slot && last_reg && footer_zero && (last_space_reg != '0)) begin
            dur_sel = last_space_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg            <= '0;
            last_reg           <= 1'b0;
            header_pending_reg <= 1'b1;
            m_valid_reg        <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            if (s_accept) begin
                last_reg           <= s_frame_end;
                header_pending_reg <= s_frame_end;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bits_reg <= bits_in;
        end
        if (out_load) begin
            m_duration_reg <= dur_sel;
            m_is_mark_reg  <= mark_sel;
            m_run_last_reg <= final_slot;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_duration = m_duration_reg;
    assign m_is_mark  = m_is_mark_reg;
    assign m_run_last = m_run_last_reg;

    // ---------------- assertions ----------------
    // a byte is taken mid-item only as its final word loads
    a_accept_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (rem_reg != '0)) |-> (out_load && final_slot))
        else $error("byte taken while slots still pending");

    // footer slots only exist for the frame's last byte
    a_footer_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg[SLOT_FTR_SPACE:SLOT_FTR_MARK] != 2'b00) |-> last_reg)
        else $error("footer slot pending on a non-final byte");

    // header due again right after a frame end byte
    a_header_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_frame_end) |=> header_pending_reg)
        else $error("header not re-armed after frame end");

    // run_last word loaded only when the slot mask empties
    a_run_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && final_slot && !s_accept) |=> (rem_reg == '0))
        else $error("slots left after final word");

endmodule
